FILE: design/vbs_pkg.sv
`timescale 1ns / 1ps
package vbs_pkg;

  localparam int SAMPLE_W    = 8;
  localparam int SUM_W       = 16;
  localparam int SHRINK_W    = 9;
  localparam int HALF_W      = SHRINK_W - 1;
  localparam int RECIP_W     = 25;
  localparam int RECIP_CNT_W = 5;
  localparam int OUT_SHIFT   = 24;
  localparam int PROD_W      = SUM_W + 1 + RECIP_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_WIDTH = 2'd0,
    CFG_SHRINK     = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_in;
  } in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_out;
    logic                end_of_line;
  } out_t;

  typedef struct packed {
    logic                start;
    logic [SHRINK_W-1:0] divisor;
  } div_req_t;

endpackage

FILE: design/vbs_stream_if.sv
`timescale 1ns / 1ps
interface vbs_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: design/vbs_recip_div.sv
`timescale 1ns / 1ps
// Restoring divider: floor(2^24 / divisor), one quotient bit per cycle.
module vbs_recip_div import vbs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  div_req_t           req_i,
  output logic               busy_o,
  output logic [RECIP_W-1:0] recip_o
);

  logic                   busy_q;
  logic [RECIP_CNT_W-1:0] cnt_q;
  logic [SHRINK_W-1:0]    div_q;
  logic [SHRINK_W-1:0]    rem_q;
  logic [RECIP_W-1:0]     quo_q;
  logic [SHRINK_W:0]      trial;
  logic [SHRINK_W:0]      rem_next;
  logic                   ge;

  // dividend is a single one in its top bit
  assign trial    = {rem_q, (cnt_q == '0)};
  assign ge       = trial >= {1'b0, div_q};
  assign rem_next = ge ? (trial - {1'b0, div_q}) : trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      div_q  <= SHRINK_W'(1);
      rem_q  <= '0;
      quo_q  <= RECIP_W'(1) << (RECIP_W - 1);
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      div_q  <= req_i.divisor;
      rem_q  <= '0;
      quo_q  <= '0;
    end else if (busy_q) begin
      rem_q <= rem_next[SHRINK_W-1:0];
      quo_q <= {quo_q[RECIP_W-2:0], ge};
      cnt_q <= cnt_q + RECIP_CNT_W'(1);
      if (cnt_q == RECIP_CNT_W'(RECIP_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o  = busy_q;
  assign recip_o = quo_q;

endmodule

FILE: design/vertical_box_shrink_u8.sv
`timescale 1ns / 1ps
// Vertical box shrink for 8-bit raster samples.
// Channels: cfg_i writes line_width (index 0) and shrink_factor (index 1);
// in_i takes one sample per beat in raster order; out_o gives one beat per
// sample on the last row of each group: the rounded column mean plus an
// end_of_line flag on the last column. Other rows produce no beat.
// Throughput: one sample per cycle while out_o takes beats and no divide runs.
// Pipeline: the edge that accepts a sample captures the sum read and the sample;
// the add goes into the stage 2 register, then the rounded, scaled mean into the
// output register. Column sums live in a single-port-write, registered-read
// memory; a read that collides with the write still in flight is forwarded.
// Reset: line width 1, shrink factor 1, reciprocal 2^24, counters zero; the
// sum memory needs no clearing since the first row of a group ignores it.
// A write to either register restarts the group. A shrink_factor write
// starts a reciprocal divide; in_i and cfg_i hold ready low until
// it is done. When out_o stalls, the pipeline holds in place and ready on
// in_i drops once every stage is full; rows with no result still drain.
module vertical_box_shrink_u8 import vbs_pkg::*; #(
  parameter int MAX_LINE_WIDTH = 4096,
  parameter int MAX_SHRINK     = 256
) (
  input logic           clk_i,
  input logic           rst_ni,
  vbs_stream_if.sink    cfg_i,
  vbs_stream_if.sink    in_i,
  vbs_stream_if.source  out_o
);

  localparam int COL_W = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
  localparam int ROW_W = (MAX_SHRINK > 1) ? $clog2(MAX_SHRINK) : 1;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic               cfg_fire, wr_width, wr_shrink, restart;
  logic [31:0]        width_eff, shrink_eff, width_m1, shrink_m1, shrink_half;
  logic [COL_W-1:0]   last_col_q;
  logic [ROW_W-1:0]   last_row_q;
  logic [HALF_W-1:0]  half_q;
  div_req_t           div_req;
  logic               div_busy;
  logic [RECIP_W-1:0] recip;

  assign cfg_fire  = cfg_i.valid && cfg_i.ready;
  assign wr_width  = cfg_fire && (cfg_i.payload.index == CFG_LINE_WIDTH);
  assign wr_shrink = cfg_fire && (cfg_i.payload.index == CFG_SHRINK);
  assign restart   = wr_width || wr_shrink;
  assign cfg_i.ready = !div_busy;

  // clamp zero to one and saturate at the storage limits
  always_comb begin
    width_eff = 32'(cfg_i.payload.data);
    if (width_eff == 32'd0) width_eff = 32'd1;
    if (width_eff > 32'(MAX_LINE_WIDTH)) width_eff = 32'(MAX_LINE_WIDTH);
    shrink_eff = 32'(cfg_i.payload.data[SHRINK_W-1:0]);
    if (shrink_eff == 32'd0) shrink_eff = 32'd1;
    if (shrink_eff > 32'(MAX_SHRINK)) shrink_eff = 32'(MAX_SHRINK);
  end

  assign width_m1    = width_eff - 32'd1;
  assign shrink_m1   = shrink_eff - 32'd1;
  assign shrink_half = shrink_eff >> 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q <= '0;
      last_row_q <= '0;
      half_q     <= '0;
    end else begin
      if (wr_width) begin
        last_col_q <= width_m1[COL_W-1:0];
      end
      if (wr_shrink) begin
        last_row_q <= shrink_m1[ROW_W-1:0];
        half_q     <= shrink_half[HALF_W-1:0];
      end
    end
  end

  assign div_req.start   = wr_shrink;
  assign div_req.divisor = shrink_eff[SHRINK_W-1:0];

  vbs_recip_div u_recip_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (div_req),
    .busy_o  (div_busy),
    .recip_o (recip)
  );

  // ---------------------------------------------------------------------------
  // Flow control: every stage advances when the one after it has room
  // ---------------------------------------------------------------------------
  logic in_fire;
  logic s1_valid_q, s1_move, s1_free;
  logic s2_valid_q, s2_move, s2_free;
  logic out_valid_q, s3_free;
  logic s2_last_row_q;

  assign s3_free = !out_valid_q || out_o.ready;
  // a beat with no result leaves stage 2 without needing the output register
  assign s2_move = s2_valid_q && (!s2_last_row_q || s3_free);
  assign s2_free = !s2_valid_q || s2_move;
  assign s1_move = s1_valid_q && s2_free;
  assign s1_free = !s1_valid_q || s1_move;

  assign in_i.ready = s1_free && !div_busy;
  assign in_fire    = in_i.valid && in_i.ready;

  // ---------------------------------------------------------------------------
  // Stage 0: column and row counters, memory read
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic             at_last_col, at_last_row;

  assign at_last_col = (col_q == last_col_q);
  assign at_last_row = (row_q == last_row_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (restart) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      if (at_last_col) begin
        col_q <= '0;
        row_q <= at_last_row ? '0 : (row_q + ROW_W'(1));
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  logic [SUM_W-1:0]    sum_mem [MAX_LINE_WIDTH];
  logic [SUM_W-1:0]    rd_q;
  logic                fwd_hit_q;
  logic [SUM_W-1:0]    fwd_data_q;
  logic [SUM_W-1:0]    s1_sum;
  logic [SAMPLE_W-1:0] s1_sample_q;
  logic [COL_W-1:0]    s1_col_q;
  logic                s1_first_q, s1_last_row_q, s1_last_col_q;

  // write the new sum as the beat leaves stage 1; registered read on accept
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      sum_mem[s1_col_q] <= s1_sum;
    end
    if (in_fire) begin
      rd_q <= sum_mem[col_q];
    end
  end

  // catch the write that lands on the same edge as the read
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      fwd_hit_q  <= s1_move && (s1_col_q == col_q);
      fwd_data_q <= s1_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_sample_q   <= in_i.payload.sample_in;
      s1_col_q      <= col_q;
      s1_first_q    <= (row_q == '0);
      s1_last_row_q <= at_last_row;
      s1_last_col_q <= at_last_col;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: accumulate (a group's first row starts from zero)
  // ---------------------------------------------------------------------------
  logic [SUM_W-1:0] s1_base;

  always_comb begin
    if (s1_first_q) begin
      s1_base = '0;
    end else if (fwd_hit_q) begin
      s1_base = fwd_data_q;
    end else begin
      s1_base = rd_q;
    end
  end

  assign s1_sum = s1_base + SUM_W'(s1_sample_q);

  logic [SUM_W-1:0] s2_sum_q;
  logic             s2_last_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_free) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      s2_sum_q      <= s1_sum;
      s2_last_row_q <= s1_last_row_q;
      s2_last_col_q <= s1_last_col_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: round and scale by the reciprocal, keep bits 31:24
  // ---------------------------------------------------------------------------
  logic [SUM_W:0]      rounded;
  logic [PROD_W-1:0]   prod;
  logic                out_load;
  logic [SAMPLE_W-1:0] out_sample_q;
  logic                out_eol_q;

  assign rounded  = {1'b0, s2_sum_q} + (SUM_W + 1)'(half_q);
  assign prod     = PROD_W'(rounded) * PROD_W'(recip);
  assign out_load = s3_free && s2_valid_q && s2_last_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s3_free) begin
      out_valid_q <= s2_valid_q && s2_last_row_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sample_q <= prod[OUT_SHIFT +: SAMPLE_W];
      out_eol_q    <= s2_last_col_q;
    end
  end

  assign out_o.valid               = out_valid_q;
  assign out_o.payload.sample_out  = out_sample_q;
  assign out_o.payload.end_of_line = out_eol_q;

endmodule

FILE: sim/vertical_box_shrink_u8_test.sv
`timescale 1ns / 1ps
module vertical_box_shrink_u8_test;
  import vbs_pkg::*;

  localparam int unsigned MAX_W     = 4096;
  localparam int unsigned MAX_V     = 256;
  localparam int          IDLE_PCT  = 37;
  localparam int          DRAIN     = 8;     // idle edges waited once no mean is owed, so the pipe drains
  localparam int          HOLD_OUT  = 300;   // long receiver hold-off, in cycles
  localparam int          WATCHDOG  = 5000;  // cycles with no beat on any channel
  localparam int          RAND_ITEMS = 200;
  localparam int          WIDE_ITEMS = 150;
  localparam int          STEADY_ITEMS = 120;
  localparam int          MAX_REPORT = 10;

  // Indexes the block has no register for; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] value;   // register data, or the sample in the low byte
    bit                    typed;   // expected mean written in the row itself
    out_t                  res;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  vbs_stream_if #(.payload_t(cfg_t)) cfg_if ();
  vbs_stream_if #(.payload_t(in_t))  in_if ();
  vbs_stream_if #(.payload_t(out_t)) out_if ();

  vertical_box_shrink_u8 uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Shadow of the block: registers, per-column sums, position in the group.
  logic [CFG_DATA_W-1:0] line_w_reg;
  logic [SHRINK_W-1:0]   shrink_reg;
  logic [SUM_W-1:0]      col_sum [MAX_W];
  int unsigned           col_pos;
  int unsigned           row_pos;
  logic [RECIP_W-1:0]    recip;

  out_t pending_means[$];   // means still owed by the block, oldest first

  bit steady_flow;          // when set, neither side inserts gaps
  bit stall_out_req;        // ask the receiver for one long hold-off

  int samples_sent;
  int writes_done;
  int means_checked;
  int mismatches;
  int idle_cycles;

  stim_row_t directed_rows[$];

  function automatic int unsigned eff_width();
    int unsigned w;
    w = line_w_reg;
    if (w == 0) w = 1;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  function automatic int unsigned eff_shrink();
    int unsigned v;
    v = shrink_reg;
    if (v == 0) v = 1;
    if (v > MAX_V) v = MAX_V;
    return v;
  endfunction

  // Restart the group: drop all sums, rewind both counters, redo the divide.
  function automatic void restart_group();
    foreach (col_sum[i]) col_sum[i] = '0;
    col_pos = 0;
    row_pos = 0;
    recip   = RECIP_W'(32'h0100_0000 / eff_shrink());
  endfunction

  function automatic void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_LINE_WIDTH: begin
        line_w_reg = d;
        restart_group();
      end
      CFG_SHRINK: begin
        shrink_reg = d[SHRINK_W-1:0];
        restart_group();
      end
      default: ;
    endcase
  endfunction

  // Advance the shadow by one sample; return 1 with the mean on the last row.
  function automatic bit column_mean_step(logic [SAMPLE_W-1:0] s, output out_t res);
    int unsigned w;
    int unsigned v;
    logic [SUM_W-1:0] sum;
    logic [31:0] prod;
    bit last_row;
    bit last_col;
    w = eff_width();
    v = eff_shrink();
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= v) row_pos = 0;
    sum      = col_sum[col_pos] + SUM_W'(s);
    last_row = (row_pos == v - 1);
    last_col = (col_pos == w - 1);
    res      = '0;
    if (last_row) begin
      // wraps mod 2^32 like the hardware product truncated to the output shift
      prod = ({16'd0, sum} + (v >> 1)) * {7'd0, recip};
      res.sample_out  = prod[31:24];
      res.end_of_line = last_col;
      col_sum[col_pos] = '0;
    end else begin
      col_sum[col_pos] = sum;
    end
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return last_row;
  endfunction

  function automatic void note_error(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORT) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  function automatic stim_row_t wr(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    stim_row_t r;
    r = '{kind: ROW_CFG, idx: idx, value: d, typed: 1'b0, res: '0};
    return r;
  endfunction

  function automatic stim_row_t smp(logic [SAMPLE_W-1:0] s);
    stim_row_t r;
    r = '{kind: ROW_SAMPLE, idx: '0, value: CFG_DATA_W'(s), typed: 1'b0, res: '0};
    return r;
  endfunction

  function automatic stim_row_t smp_chk(logic [SAMPLE_W-1:0] s, logic [SAMPLE_W-1:0] m,
                                        logic eol);
    stim_row_t r;
    r = '{kind: ROW_SAMPLE, idx: '0, value: CFG_DATA_W'(s), typed: 1'b1,
          res: '{sample_out: m, end_of_line: eol}};
    return r;
  endfunction

  // Mostly uniform; push the extremes a little more often.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 15))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return SAMPLE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one sample beat, after an optional random gap; predict on acceptance.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit typed,
                             input out_t typed_res);
    out_t predicted;
    bit   has_mean;
    if (!steady_flow) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= '{sample_in: s};
    do @(posedge clk_i); while (!in_if.ready);
    samples_sent++;
    has_mean = column_mean_step(s, predicted);
    if (typed) pending_means.push_back(typed_res);
    else if (has_mean) pending_means.push_back(predicted);
  endtask

  // Hold the input quiet until the block owes nothing and its pipe has drained.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= '{index: idx, data: d};
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    apply_config(idx, d);
    writes_done++;
  endtask

  // One configuration followed by a stream of n samples.
  task automatic run_phase(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] v,
                           input int n, input bit all_max);
    settle();
    if ($urandom_range(0, 1)) begin
      cfg_write(CFG_LINE_WIDTH, w);
      settle();
      cfg_write(CFG_SHRINK, v);
    end else begin
      cfg_write(CFG_SHRINK, v);
      settle();
      cfg_write(CFG_LINE_WIDTH, w);
    end
    repeat (n) send_sample(all_max ? 8'hFF : pick_sample(), 1'b0, '0);
  endtask

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random back-pressure, a long hold-off on request, none while steady.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_out_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_OUT) @(posedge clk_i);
        stall_out_req = 1'b0;
      end else begin
        out_if.ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Check every result beat against the oldest owed mean, field by field.
  always @(posedge clk_i) begin
    out_t want;
    if (out_if.valid && out_if.ready) begin
      if (pending_means.size() == 0) begin
        note_error($sformatf("unexpected beat sample_out=%0d end_of_line=%0b",
                             out_if.payload.sample_out, out_if.payload.end_of_line));
      end else begin
        want = pending_means.pop_front();
        means_checked++;
        if (out_if.payload.sample_out !== want.sample_out)
          note_error($sformatf("sample_out expected %0d got %0d",
                               want.sample_out, out_if.payload.sample_out));
        if (out_if.payload.end_of_line !== want.end_of_line)
          note_error($sformatf("end_of_line expected %0b got %0b",
                               want.end_of_line, out_if.payload.end_of_line));
      end
    end
  end

  // Watchdog: end the run if no channel moves a beat for too long.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("timeout: no beat for %0d cycles, %0d means still owed",
               WATCHDOG, pending_means.size());
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int rand_items;
    int unsigned w;
    int unsigned v;
    int unsigned per_group;
    int n;

    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    steady_flow    = 1'b0;
    stall_out_req  = 1'b0;
    samples_sent   = 0;
    writes_done    = 0;
    means_checked  = 0;
    mismatches     = 0;
    idle_cycles    = 0;
    rand_items     = 0;
    line_w_reg     = 1;
    shrink_reg     = 1;
    restart_group();

    // After reset: width 1, shrink 1, so every sample comes straight back
    // with end_of_line set.
    directed_rows.push_back(smp_chk(8'h00, 8'h00, 1'b1));
    directed_rows.push_back(smp_chk(8'hFF, 8'hFF, 1'b1));
    directed_rows.push_back(smp_chk(8'hAA, 8'hAA, 1'b1));
    directed_rows.push_back(smp_chk(8'h55, 8'h55, 1'b1));
    // Pairs of rows: half-up rounding of 255+255 and of 0+1.
    directed_rows.push_back(wr(CFG_SHRINK, 13'd2));
    directed_rows.push_back(smp(8'hFF));
    directed_rows.push_back(smp_chk(8'hFF, 8'hFF, 1'b1));
    directed_rows.push_back(smp(8'h00));
    directed_rows.push_back(smp_chk(8'h01, 8'h01, 1'b1));
    // Zero shrink factor and zero line width both act as 1.
    directed_rows.push_back(wr(CFG_SHRINK, 13'd0));
    directed_rows.push_back(smp_chk(8'h07, 8'h07, 1'b1));
    directed_rows.push_back(wr(CFG_LINE_WIDTH, 13'd0));
    directed_rows.push_back(smp_chk(8'h33, 8'h33, 1'b1));
    // Three columns: end_of_line only on the last.
    directed_rows.push_back(wr(CFG_LINE_WIDTH, 13'd3));
    directed_rows.push_back(smp_chk(8'h01, 8'h01, 1'b0));
    directed_rows.push_back(smp_chk(8'h02, 8'h02, 1'b0));
    directed_rows.push_back(smp_chk(8'h03, 8'h03, 1'b1));
    // Writes to unused indexes must not disturb the column position.
    directed_rows.push_back(wr(CFG_LINE_WIDTH, 13'd2));
    directed_rows.push_back(smp_chk(8'h10, 8'h10, 1'b0));
    directed_rows.push_back(wr(CFG_SPARE_2, 13'h1FFF));
    directed_rows.push_back(smp_chk(8'h20, 8'h20, 1'b1));
    directed_rows.push_back(wr(CFG_SPARE_3, 13'h0000));
    directed_rows.push_back(smp_chk(8'h30, 8'h30, 1'b0));
    // A register write mid-group drops the partial sums.
    directed_rows.push_back(wr(CFG_SHRINK, 13'd2));
    directed_rows.push_back(smp(8'd10));
    directed_rows.push_back(wr(CFG_LINE_WIDTH, 13'd2));
    directed_rows.push_back(smp(8'd20));
    directed_rows.push_back(smp(8'd30));
    directed_rows.push_back(smp_chk(8'd40, 8'd30, 1'b0));
    directed_rows.push_back(smp_chk(8'd50, 8'd40, 1'b1));

    // Hold reset, then release it on a clock edge.
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        settle();
        cfg_write(directed_rows[i].idx, directed_rows[i].value);
      end else begin
        send_sample(directed_rows[i].value[SAMPLE_W-1:0], directed_rows[i].typed,
                    directed_rows[i].res);
      end
    end

    // Widest line, saturated from an all-ones write; shrink 1 gives a mean per
    // sample, so the hold-off below fills the pipe and must stall the input.
    settle();
    cfg_write(CFG_LINE_WIDTH, 13'h1FFF);
    settle();
    cfg_write(CFG_SHRINK, 13'd1);
    stall_out_req = 1'b1;
    repeat (WIDE_ITEMS) send_sample(pick_sample(), 1'b0, '0);

    // Deepest group with full-scale samples: largest column sum. The shrink
    // write has high bits set: masked to 511, then saturated to 256.
    run_phase(13'd1, 13'h1FFF, MAX_V, 1'b1);

    // Exact maximum width, back to back with no gaps on either side.
    steady_flow = 1'b1;
    run_phase(13'd4096, 13'd1, STEADY_ITEMS, 1'b0);
    settle();
    steady_flow = 1'b0;

    // Random phases: mostly whole groups, sometimes a trailing partial group
    // that the next write throws away.
    while (rand_items < RAND_ITEMS) begin
      if ($urandom_range(0, 5) == 0) begin
        w = $urandom_range(17, 48);
        v = $urandom_range(1, 2);
      end else if ($urandom_range(0, 7) == 0) begin
        w = $urandom_range(0, 4);
        v = $urandom_range(10, 20);
      end else begin
        w = $urandom_range(0, 16);
        v = $urandom_range(0, 9);
      end
      per_group = (w == 0 ? 1 : w) * (v == 0 ? 1 : v);
      n = per_group * $urandom_range(1, 2);
      if (per_group > 1 && $urandom_range(0, 3) == 0) n += $urandom_range(1, per_group - 1);
      run_phase(CFG_DATA_W'(w), CFG_DATA_W'(v), n, 1'b0);
      rand_items += n;
    end

    settle();

    $display("Sent %0d samples over %0d register writes; checked %0d means.",
             samples_sent, writes_done, means_checked);
    $display("Widths 1..4096 and shrink 1..256 with saturation, %0d mismatches.",
             mismatches);
    if (mismatches == 0 && pending_means.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
